>>> hdl/mer_pkg.sv
// Package for the midpoint ellipse rasterizer: datapath operation codes and the
// command/status structs exchanged by the controller and the datapath.
// No dependencies.
package mer_pkg;

    // Datapath operations, one per cycle, issued by the controller
    typedef enum logic [3:0] {
        OP_NOP          = 4'd0,
        OP_LOAD         = 4'd1,   // latch radii, place walk at (0, ry)
        OP_MUL_RXRX     = 4'd2,   // prod = rx * rx
        OP_MUL_RYRY     = 4'd3,   // rx^2 = prod, prod = ry * ry
        OP_MUL_RXSQ_RY  = 4'd4,   // ry^2 = prod, prod = rx^2 * ry
        OP_INIT         = 4'd5,   // region 1 gradient and decision set-up
        OP_STEP         = 4'd6,   // one walk step, emits a result
        OP_MUL_TX       = 4'd7,   // prod = (2x+1)^2
        OP_MUL_RYSQ_P   = 4'd8,   // prod = ry^2 * prod
        OP_MUL_YM       = 4'd9,   // dec = prod, prod = (y-1)^2
        OP_MUL_RXSQ_P   = 4'd10,  // prod = rx^2 * prod
        OP_MUL_RXSQ_RYSQ = 4'd11, // dec += 4*prod, prod = rx^2 * ry^2
        OP_SWITCH       = 4'd12   // dec -= 4*prod, enter region 2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic need_switch; // region 1 is over, region 2 set-up needed
        logic out_busy;    // output register holds a result not taken this cycle
    } t_dp_stat;

endpackage

>>> hdl/mer_if.sv
// Valid/ready channel interfaces for the midpoint ellipse rasterizer:
// input items (mode and radii) and result items (point and flags).
// No dependencies.
interface mer_in_if #(
    parameter int RADIUS_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, output mode, output radius_x, output radius_y,
                    input ready);
    modport sink   (input valid, input mode, input radius_x, input radius_y,
                    output ready);
endinterface

interface mer_out_if #(
    parameter int RADIUS_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [RADIUS_BITS-1:0] point_x;
    logic [RADIUS_BITS-1:0] point_y;
    logic                   point_valid;
    logic                   done_res;

    modport source (output valid, output point_x, output point_y, output point_valid,
                    output done_res, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_valid,
                    input done_res, output ready);
endinterface

>>> hdl/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer: sequences start set-up,
// walk steps and the region 2 set-up over the shared multiplier.
// Depends on mer_pkg.
module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    input  mer_pkg::t_dp_stat i_stat,
    output mer_pkg::t_dp_cmd  o_cmd
);
    import mer_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SQX  = 12'b0000_0000_0010,
        ST_SQY  = 12'b0000_0000_0100,
        ST_RXY  = 12'b0000_0000_1000,
        ST_INIT = 12'b0000_0001_0000,
        ST_STEP = 12'b0000_0010_0000,
        ST_TX   = 12'b0000_0100_0000,
        ST_A    = 12'b0000_1000_0000,
        ST_YM   = 12'b0001_0000_0000,
        ST_B    = 12'b0010_0000_0000,
        ST_C    = 12'b0100_0000_0000,
        ST_SW   = 12'b1000_0000_0000
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NOP;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_mode) begin
                        n_state = ST_STEP;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state  = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                o_cmd.op = OP_MUL_RXRX;
                n_state  = ST_SQY;
            end
            ST_SQY: begin
                o_cmd.op = OP_MUL_RYRY;
                n_state  = ST_RXY;
            end
            ST_RXY: begin
                o_cmd.op = OP_MUL_RXSQ_RY;
                n_state  = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = ST_IDLE;
            end
            ST_STEP: begin
                if (i_stat.need_switch) begin
                    n_state = ST_TX;
                end else if (!i_stat.out_busy) begin
                    o_cmd.op = OP_STEP;
                    n_state  = ST_IDLE;
                end
            end
            ST_TX: begin
                o_cmd.op = OP_MUL_TX;
                n_state  = ST_A;
            end
            ST_A: begin
                o_cmd.op = OP_MUL_RYSQ_P;
                n_state  = ST_YM;
            end
            ST_YM: begin
                o_cmd.op = OP_MUL_YM;
                n_state  = ST_B;
            end
            ST_B: begin
                o_cmd.op = OP_MUL_RXSQ_P;
                n_state  = ST_C;
            end
            ST_C: begin
                o_cmd.op = OP_MUL_RXSQ_RYSQ;
                n_state  = ST_SW;
            end
            ST_SW: begin
                o_cmd.op = OP_SWITCH;
                n_state  = ST_STEP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/mer_datapath.sv
// Datapath of the midpoint ellipse rasterizer: walk state, gradients, decision,
// one shared registered multiplier and the output register.
// Depends on mer_pkg.
module mer_datapath #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mer_pkg::t_dp_cmd       i_cmd,
    input  logic [RADIUS_BITS-1:0] i_radius_x,
    input  logic [RADIUS_BITS-1:0] i_radius_y,
    output mer_pkg::t_dp_stat      o_stat,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [RADIUS_BITS-1:0] o_point_x,
    output logic [RADIUS_BITS-1:0] o_point_y,
    output logic                   o_point_valid,
    output logic                   o_done_res
);
    import mer_pkg::*;

    localparam int R  = RADIUS_BITS;
    localparam int SW = 2 * R;       // squared radius
    localparam int YW = R + 1;       // signed y, ends at -1
    localparam int GW = 3 * R + 2;   // signed gradient
    localparam int DW = 4 * R + 8;   // signed decision, 4x scaled
    localparam int MW = 2 * R + 5;   // signed multiplier operand

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_R1   = 2'd1,
        PH_R2   = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    logic [R-1:0]         r_rx;
    logic [R-1:0]         r_ry;
    logic [SW-1:0]        r_rxsq;
    logic [SW-1:0]        r_rysq;
    logic [R-1:0]         r_x;
    logic signed [YW-1:0] r_y;
    logic signed [GW-1:0] r_gx;
    logic signed [GW-1:0] r_gy;
    logic signed [DW-1:0] r_dec;
    logic signed [DW-1:0] r_prod;
    t_phase               r_phase;

    logic                 r_out_valid;
    logic [R-1:0]         r_pt_x;
    logic [R-1:0]         r_pt_y;
    logic                 r_pt_valid;
    logic                 r_done;

    logic signed [MW-1:0]   w_mul_a;
    logic signed [MW-1:0]   w_mul_b;
    logic signed [2*MW-1:0] w_mul;
    logic signed [YW:0]     w_ym1;
    logic signed [GW-1:0]   w_gx_inc;
    logic signed [GW-1:0]   w_gy_dec;
    logic signed [DW-1:0]   w_gx_inc_d;
    logic signed [DW-1:0]   w_gy_dec_d;
    logic signed [DW-1:0]   w_rxsq_d;
    logic signed [DW-1:0]   w_rysq_d;
    logic                   w_emit;
    logic                   w_dec_neg;
    logic                   w_dec_pos;

    // Step arithmetic
    assign w_ym1      = YW'(r_y) - (YW + 1)'(1);
    assign w_gx_inc   = r_gx + signed'(GW'({r_rysq, 1'b0}));
    assign w_gy_dec   = r_gy - signed'(GW'({r_rxsq, 1'b0}));
    assign w_gx_inc_d = DW'(w_gx_inc);
    assign w_gy_dec_d = DW'(w_gy_dec);
    assign w_rxsq_d   = signed'(DW'(r_rxsq));
    assign w_rysq_d   = signed'(DW'(r_rysq));
    assign w_dec_neg  = r_dec[DW-1];
    assign w_dec_pos  = !r_dec[DW-1] && (r_dec != '0);
    assign w_emit     = (i_cmd.op == OP_STEP);

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_MUL_RXRX: begin
                w_mul_a = signed'(MW'(r_rx));
                w_mul_b = signed'(MW'(r_rx));
            end
            OP_MUL_RYRY: begin
                w_mul_a = signed'(MW'(r_ry));
                w_mul_b = signed'(MW'(r_ry));
            end
            OP_MUL_RXSQ_RY: begin
                w_mul_a = signed'(MW'(r_rxsq));
                w_mul_b = signed'(MW'(r_ry));
            end
            OP_MUL_TX: begin
                w_mul_a = signed'(MW'({r_x, 1'b1}));
                w_mul_b = signed'(MW'({r_x, 1'b1}));
            end
            OP_MUL_RYSQ_P: begin
                w_mul_a = signed'(MW'(r_rysq));
                w_mul_b = r_prod[MW-1:0];
            end
            OP_MUL_YM: begin
                w_mul_a = MW'(w_ym1);
                w_mul_b = MW'(w_ym1);
            end
            OP_MUL_RXSQ_P: begin
                w_mul_a = signed'(MW'(r_rxsq));
                w_mul_b = r_prod[MW-1:0];
            end
            OP_MUL_RXSQ_RYSQ: begin
                w_mul_a = signed'(MW'(r_rxsq));
                w_mul_b = signed'(MW'(r_rysq));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul[DW-1:0];
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_rx <= i_radius_x;
                    r_ry <= i_radius_y;
                    r_x  <= '0;
                    r_y  <= signed'(YW'(i_radius_y));
                    r_gx <= '0;
                end
                OP_MUL_RYRY: begin
                    r_rxsq <= r_prod[SW-1:0];
                end
                OP_MUL_RXSQ_RY: begin
                    r_rysq <= r_prod[SW-1:0];
                end
                OP_INIT: begin
                    r_gy    <= {r_prod[GW-2:0], 1'b0};
                    r_dec   <= (w_rysq_d <<< 2) - (r_prod <<< 2) + w_rxsq_d;
                    r_phase <= PH_R1;
                end
                OP_MUL_YM: begin
                    r_dec <= r_prod;
                end
                OP_MUL_RXSQ_RYSQ: begin
                    r_dec <= r_dec + (r_prod <<< 2);
                end
                OP_SWITCH: begin
                    r_dec   <= r_dec - (r_prod <<< 2);
                    r_phase <= PH_R2;
                end
                OP_STEP: begin
                    case (r_phase)
                        PH_R1: begin
                            r_x  <= r_x + R'(1);
                            r_gx <= w_gx_inc;
                            if (w_dec_neg) begin
                                r_dec <= r_dec + ((w_gx_inc_d + w_rysq_d) <<< 2);
                            end else begin
                                r_y   <= r_y - YW'(1);
                                r_gy  <= w_gy_dec;
                                r_dec <= r_dec
                                         + ((w_gx_inc_d - w_gy_dec_d + w_rysq_d) <<< 2);
                            end
                        end
                        PH_R2: begin
                            if (r_y[YW-1]) begin
                                r_phase <= PH_DONE;
                            end else begin
                                r_y  <= r_y - YW'(1);
                                r_gy <= w_gy_dec;
                                if (w_dec_pos) begin
                                    r_dec <= r_dec + ((w_rxsq_d - w_gy_dec_d) <<< 2);
                                end else begin
                                    r_x   <= r_x + R'(1);
                                    r_gx  <= w_gx_inc;
                                    r_dec <= r_dec
                                             + ((w_gx_inc_d - w_gy_dec_d + w_rxsq_d) <<< 2);
                                end
                            end
                        end
                        default: begin
                            r_phase <= r_phase;
                        end
                    endcase
                end
                default: begin
                    r_phase <= r_phase;
                end
            endcase
        end
    end

    // Output register: valid held until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; idle/finished and y below zero give a done result
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if ((r_phase == PH_R1) || ((r_phase == PH_R2) && !r_y[YW-1])) begin
                r_pt_x     <= r_x;
                r_pt_y     <= r_y[R-1:0];
                r_pt_valid <= 1'b1;
                r_done     <= 1'b0;
            end else begin
                r_pt_x     <= '0;
                r_pt_y     <= '0;
                r_pt_valid <= 1'b0;
                r_done     <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_pt_x;
    assign o_point_y     = r_pt_y;
    assign o_point_valid = r_pt_valid;
    assign o_done_res    = r_done;

    // Status to the controller
    assign o_stat.need_switch = (r_phase == PH_R1) && !(r_gx < r_gy);
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;

endmodule

>>> hdl/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Depends on mer_pkg, mer_if (mer_in_if, mer_out_if), mer_ctrl, mer_datapath.
//
//  channel  dir  payload                                      handshake
//  i_in     in   mode, radius_x, radius_y                     valid/ready
//  o_out    out  point_x, point_y, point_valid, done_res      valid/ready
//
// A step transaction passes accept and execute; the step that ends region 1 first passes
// a check and the region 2 set-up states TX, A, YM, B, C, SW on the shared multiplier.
// A start transaction returns no result: load, three multiplies (SQX, SQY, RXY), INIT.
// Reset (synchronous, active low) returns the walk to idle: a step then reports done.
// A stalled result is held in the output register; the next item is still taken,
// and its step waits in the execute cycle until the register is free.
module midpoint_ellipse_rasterizer_unit #(
    parameter int RADIUS_BITS = 10
) (
    input logic      i_clk,
    input logic      i_rst_n,
    mer_in_if.sink   i_in,
    mer_out_if.source o_out
);
    import mer_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_radius_x    (i_in.radius_x),
        .i_radius_y    (i_in.radius_y),
        .o_stat        (w_stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_point_x     (o_out.point_x),
        .o_point_y     (o_out.point_y),
        .o_point_valid (o_out.point_valid),
        .o_done_res    (o_out.done_res)
    );

    assign i_in.ready = w_in_ready;

    // No back-to-back accepts: every item needs its own execute cycle
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted in two consecutive cycles");

    // A start transaction never raises a result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.mode) |=> !$rose(o_out.valid))
        else $error("result raised after a start transaction");

    // A result is either a point or done, never both or neither
    a_point_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.point_valid != o_out.done_res))
        else $error("result flags inconsistent");

    // A done result carries zero coordinates
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |-> ((o_out.point_x == '0) && (o_out.point_y == '0)))
        else $error("done result with nonzero coordinates");

endmodule

>>> bench/tb.sv
// Self-checking bench for midpoint_ellipse_rasterizer_unit: random valid/ready traffic on
// both channels, with an in-bench model of the first-quadrant ellipse walk.
// Depends on mer_pkg, mer_if (mer_in_if, mer_out_if) and the RTL under hdl/.
module tb;

    localparam int RB = 10;

    // Command encoding on the input channel
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Idle-free window, in clock cycles after time zero
    localparam int QUIET_FROM = 800;
    localparam int QUIET_TO   = 1800;
    localparam int PAUSE_PCT  = 6;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_REGION1,
        WALK_REGION2,
        WALK_FINISHED
    } walk_phase_t;

    typedef struct packed {
        logic          mode;
        logic [RB-1:0] radius_x;
        logic [RB-1:0] radius_y;
    } ellipse_cmd_t;

    typedef struct packed {
        logic [RB-1:0] point_x;
        logic [RB-1:0] point_y;
        logic          point_valid;
        logic          done_res;
    } ellipse_point_t;

    logic i_clk;
    logic i_rst_n;

    mer_in_if  #(.RADIUS_BITS(RB)) in_if ();
    mer_out_if #(.RADIUS_BITS(RB)) out_if ();

    midpoint_ellipse_rasterizer_unit #(
        .RADIUS_BITS(RB)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ellipse_cmd_t   pending_cmds[$];
    ellipse_point_t expected_points[$];
    int             error_count = 0;
    int             cycle_count = 0;

    // Walk state; 64-bit arithmetic keeps every decision term exact
    walk_phase_t        walk_phase;
    logic [63:0]        walk_x;
    logic signed [63:0] walk_y;
    logic [63:0]        grad_x;
    logic [63:0]        grad_y;
    logic [63:0]        decision;
    logic [63:0]        rx_sq;
    logic [63:0]        ry_sq;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Random pause, off inside the quiet window
    function automatic bit take_pause();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < PAUSE_PCT;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    function automatic ellipse_point_t make_point(input logic [63:0] x, input logic [63:0] y,
                                                  input logic vld, input logic fin);
        ellipse_point_t p;
        p.point_x     = x[RB-1:0];
        p.point_y     = y[RB-1:0];
        p.point_valid = vld;
        p.done_res    = fin;
        return p;
    endfunction

    // Advance the ellipse walk by one command; a step yields exactly one result, a point or done
    task automatic advance_walk(input ellipse_cmd_t cmd, output bit has_point,
                                output ellipse_point_t pt);
        logic [63:0] rx, ry, tx, ym1, px, py;
        has_point = 1'b0;
        pt        = '0;
        if (cmd.mode == MODE_START) begin
            rx         = 64'(cmd.radius_x);
            ry         = 64'(cmd.radius_y);
            rx_sq      = rx * rx;
            ry_sq      = ry * ry;
            walk_x     = '0;
            walk_y     = $signed(ry);
            grad_x     = '0;
            grad_y     = 64'd2 * rx_sq * ry;
            decision   = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
            walk_phase = WALK_REGION1;
            return;
        end
        has_point = 1'b1;
        if (walk_phase == WALK_IDLE || walk_phase == WALK_FINISHED) begin
            pt = make_point(0, 0, 1'b0, 1'b1);
            return;
        end
        if (walk_phase == WALK_REGION1) begin
            if (grad_x < grad_y) begin
                px = walk_x;
                py = $unsigned(walk_y);
                walk_x = walk_x + 1;
                grad_x = grad_x + 64'd2 * ry_sq;
                if (decision[63]) begin
                    decision = decision + 64'd4 * (grad_x + ry_sq);
                end else begin
                    walk_y   = walk_y - 1;
                    grad_y   = grad_y - 64'd2 * rx_sq;
                    decision = decision + 64'd4 * (grad_x - grad_y + ry_sq);
                end
                pt = make_point(px, py, 1'b1, 1'b0);
                return;
            end
            // Region 1 over: set up region 2 and fall through to its first point
            tx         = 64'd2 * walk_x + 64'd1;
            ym1        = $unsigned(walk_y) - 64'd1;
            decision   = ry_sq * tx * tx + 64'd4 * rx_sq * ym1 * ym1
                         - 64'd4 * rx_sq * ry_sq;
            walk_phase = WALK_REGION2;
        end
        if (walk_y < 0) begin
            walk_phase = WALK_FINISHED;
            pt = make_point(0, 0, 1'b0, 1'b1);
            return;
        end
        px     = walk_x;
        py     = $unsigned(walk_y);
        walk_y = walk_y - 1;
        if (!decision[63] && decision != 64'd0) begin
            grad_y   = grad_y - 64'd2 * rx_sq;
            decision = decision + 64'd4 * (rx_sq - grad_y);
        end else begin
            walk_x   = walk_x + 1;
            grad_x   = grad_x + 64'd2 * ry_sq;
            grad_y   = grad_y - 64'd2 * rx_sq;
            decision = decision + 64'd4 * (grad_x - grad_y + rx_sq);
        end
        pt = make_point(px, py, 1'b1, 1'b0);
    endtask

    // Stimulus helpers
    task automatic push_start(input int rx, input int ry);
        pending_cmds.push_back('{MODE_START, RB'(rx), RB'(ry)});
    endtask

    task automatic push_steps(input int n);
        repeat (n) pending_cmds.push_back('{MODE_STEP, RB'($urandom), RB'($urandom)});
    endtask

    // Input driver: presents queued commands, models accepted ones
    always @(posedge i_clk) begin
        ellipse_cmd_t   nxt;
        ellipse_point_t pt;
        bit             has_point;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                advance_walk('{in_if.mode, in_if.radius_x, in_if.radius_y}, has_point, pt);
                if (has_point) expected_points.push_back(pt);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_cmds.size() != 0 && !take_pause()) begin
                    nxt = pending_cmds.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.mode     <= nxt.mode;
                    in_if.radius_x <= nxt.radius_x;
                    in_if.radius_y <= nxt.radius_y;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random backpressure, in-order compare
    always @(posedge i_clk) begin
        ellipse_point_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_points.size() == 0) begin
                    flag_error($sformatf("unexpected result x=%0d y=%0d valid=%0b done=%0b",
                                         out_if.point_x, out_if.point_y,
                                         out_if.point_valid, out_if.done_res));
                end else begin
                    want = expected_points.pop_front();
                    check_field("point_x", want.point_x, out_if.point_x);
                    check_field("point_y", want.point_y, out_if.point_y);
                    check_field("point_valid", want.point_valid, out_if.point_valid);
                    check_field("done_res", want.done_res, out_if.done_res);
                end
            end
            out_if.ready <= !take_pause();
        end
    end

    // Sequence, reset and end of test
    initial begin
        int sel, rx, ry;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_START;
        in_if.radius_x  = '0;
        in_if.radius_y  = '0;
        out_if.ready    = 1'b0;
        walk_phase      = WALK_IDLE;
        walk_x          = '0;
        walk_y          = '0;
        grad_x          = '0;
        grad_y          = '0;
        decision        = '0;
        rx_sq           = '0;
        ry_sq           = '0;

        // Directed: step before any start, zero radii, largest radii
        push_steps(2);
        push_start(0, 3);
        push_steps(5);
        push_start(5, 0);
        push_steps(3);
        push_start(1023, 1023);
        push_steps(3);
        push_start(1023, 1);
        push_steps(2);
        push_start(1, 1023);
        push_steps(2);
        push_start(0, 0);
        push_steps(2);

        // Random: mostly complete walks, some cut short, some noise
        while (pending_cmds.size() < 1000) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                if ($urandom_range(0, 9) == 0) begin
                    rx = $urandom_range(0, 150);
                    ry = $urandom_range(0, 150);
                end else begin
                    rx = $urandom_range(0, 24);
                    ry = $urandom_range(0, 24);
                end
                push_start(rx, ry);
                // rx + ry + 2 steps always reach the end of the walk
                push_steps(rx + ry + 2 + $urandom_range(0, 2));
            end else if (sel < 85) begin
                push_start($urandom_range(0, 1023), $urandom_range(0, 1023));
                push_steps($urandom_range(0, 20));
            end else begin
                pending_cmds.push_back(ellipse_cmd_t'($urandom));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_if.valid) @(negedge i_clk);
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
